FILE: src/ddsq_pkg.sv
// Package for the due-date sorted queue: entry type, codes and date tables.
// Used by every module of the block; depends on nothing.
package ddsq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_PAST      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

  localparam logic [0:0] CFG_TODAY_MONTH = 1'b0;
  localparam logic [0:0] CFG_TODAY_DAY   = 1'b1;
  localparam logic [2:0] MAX_COURSE      = 3'd5;

  typedef struct packed {
    logic [2:0] course;
    logic [7:0] number;
    logic [3:0] month;
    logic [4:0] day;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the request
    logic scan;   // run the compare pass over all entries
    logic shift;  // apply the insert or remove to the entry row
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_shift;
  } dp_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
      4'd2:                                       month_len = 5'd28;
      default:                                    month_len = 5'd0;
    endcase
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd0, 4'd1: cum_days = 9'd0;
      4'd2:       cum_days = 9'd31;
      4'd3:       cum_days = 9'd59;
      4'd4:       cum_days = 9'd90;
      4'd5:       cum_days = 9'd120;
      4'd6:       cum_days = 9'd151;
      4'd7:       cum_days = 9'd181;
      4'd8:       cum_days = 9'd212;
      4'd9:       cum_days = 9'd243;
      4'd10:      cum_days = 9'd273;
      4'd11:      cum_days = 9'd304;
      default:    cum_days = 9'd334;
    endcase
  endfunction

  function automatic logic [8:0] day_of_year(input logic [3:0] m, input logic [4:0] d);
    day_of_year = cum_days(m) + {4'd0, d};
  endfunction

endpackage

FILE: src/due_date_sorted_queue.sv
// Top level of the due-date sorted queue.
// Instantiates ddsq_ctrl and ddsq_datapath; depends on ddsq_pkg.
//
// The block holds up to QUEUE_DEPTH entries sorted by due date and serves
// one item at a time: each item is captured, compared in one pass against
// the entry row, applied to the row by a shift where it inserts or removes
// an entry, and then its result is offered; the next item is taken only
// after that result has been taken. The compare pass checks all entries in
// parallel and the shift moves the whole row at once.
// The current date comes from two registers written on the configuration
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. Entries are not cleared by reset; the
// entry count, the date registers and the pending shift flags are, and
// slots at or past the count never affect a result.
module due_date_sorted_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  course_code_i,
  input  logic [7:0]  assignment_number_i,
  input  logic [3:0]  due_month_i,
  input  logic [4:0]  due_day_i,
  input  logic        has_description_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  head_course_o,
  output logic [7:0]  head_number_o,
  output logic [3:0]  head_month_o,
  output logic [4:0]  head_day_o,
  output logic [8:0]  days_left_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import ddsq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_st;

  ddsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_st),
    .cmd_o       (cmd)
  );

  ddsq_datapath #(.QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (dp_st),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .opcode_i            (opcode_i),
    .course_code_i       (course_code_i),
    .assignment_number_i (assignment_number_i),
    .due_month_i         (due_month_i),
    .due_day_i           (due_day_i),
    .has_description_i   (has_description_i),
    .res_status_o        (status_o),
    .head_course_o       (head_course_o),
    .head_number_o       (head_number_o),
    .head_month_o        (head_month_o),
    .head_day_o          (head_day_o),
    .days_left_o         (days_left_o)
  );

  // An accepted item always leads to a scan in the next cycle.
  a_load_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd.scan) else $error("scan did not follow accept");

  // The block never takes an item while a result is offered.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  // A row shift only happens in the cycle after a scan.
  a_shift_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> $past(cmd.scan)) else $error("shift without scan");

endmodule

FILE: src/ddsq_ctrl.sv
// Controller state machine of the due-date sorted queue.
// Depends on ddsq_pkg; drives the datapath through dp_cmd_t.
module ddsq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ddsq_pkg::dp_status_t   status_i,
  output ddsq_pkg::dp_cmd_t      cmd_o
);
  import ddsq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   state_d = S_SHIFT;
      S_SHIFT:  state_d = S_RESULT;
      S_RESULT: if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN:   cmd_o.scan = 1'b1;
      S_SHIFT:  cmd_o.shift = status_i.needs_shift;
      S_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/ddsq_datapath.sv
// Datapath of the due-date sorted queue: entry row, checks and result.
// Depends on ddsq_pkg; commanded by ddsq_ctrl.
module ddsq_datapath #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ddsq_pkg::dp_cmd_t     cmd_i,
  output ddsq_pkg::dp_status_t  status_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [4:0]            cfg_data_i,
  input  logic [1:0]            opcode_i,
  input  logic [2:0]            course_code_i,
  input  logic [7:0]            assignment_number_i,
  input  logic [3:0]            due_month_i,
  input  logic [4:0]            due_day_i,
  input  logic                  has_description_i,
  output logic [2:0]            res_status_o,
  output logic [2:0]            head_course_o,
  output logic [7:0]            head_number_o,
  output logic [3:0]            head_month_o,
  output logic [4:0]            head_day_o,
  output logic [8:0]            days_left_o
);
  import ddsq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            row_q [QueueDepth];
  logic [CntW-1:0]   count_q;
  logic [3:0]        today_m_q;
  logic [4:0]        today_d_q;

  logic [1:0]        op_q;
  entry_t            req_q;
  logic              desc_q;

  // Scan results.
  logic [CntW-1:0]   pos_q;
  logic              ins_q, rem_q;
  logic [2:0]        st_q;
  entry_t            head_q;
  logic [8:0]        left_q;

  // Combinational scan over independent entries.
  logic [QueueDepth-1:0] live, dup, later, crs;
  logic [CntW-1:0]   pos_c;
  logic              found_c;
  entry_t            hit_c;
  logic [3:0]        now_m;
  logic [8:0]        now_doy, due_doy;
  logic [4:0]        mlen;
  logic              bad_c, past_c;

  always_comb begin
    now_m = (today_m_q == 4'd0) ? 4'd1 : (today_m_q > 4'd12 ? 4'd12 : today_m_q);
    now_doy = cum_days(now_m) + {4'd0, today_d_q};
    mlen = month_len(req_q.month);
    bad_c = (req_q.course > MAX_COURSE) || !desc_q || (mlen == 5'd0) ||
            (req_q.day == 5'd0) || (req_q.day > mlen);
    past_c = day_of_year(req_q.month, req_q.day) < now_doy;
    for (int i = 0; i < QueueDepth; i++) begin
      live[i]  = CntW'(i) < count_q;
      dup[i]   = live[i] && (row_q[i] == req_q);
      later[i] = live[i] && ({row_q[i].month, row_q[i].day} > {req_q.month, req_q.day});
      crs[i]   = live[i] && (row_q[i].course == req_q.course);
    end
    // Entries are sorted, so the insert point is the number of entries not later.
    pos_c = count_q;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (later[i]) pos_c = CntW'(i);
    end
    found_c = |crs;
    hit_c = row_q[0];
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (crs[i]) hit_c = row_q[i];
    end
    due_doy = day_of_year(hit_c.month, hit_c.day);
  end

  assign status_o.needs_shift = ins_q || rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      today_m_q <= 4'd1;
      today_d_q <= 5'd1;
      ins_q     <= 1'b0;
      rem_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TODAY_MONTH) today_m_q <= cfg_data_i[3:0];
        else today_d_q <= cfg_data_i;
      end
      if (cmd_i.scan) begin
        ins_q <= 1'b0;
        rem_q <= 1'b0;
        case (op_e'(op_q))
          OP_ENQ: begin
            if (!bad_c && !past_c && !(|dup) && count_q != CntW'(QueueDepth)) ins_q <= 1'b1;
          end
          OP_DEQ:  if (count_q != '0) rem_q <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.shift) begin
        if (ins_q) count_q <= count_q + CntW'(1);
        else count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      req_q  <= '{course: course_code_i, number: assignment_number_i,
                  month: due_month_i, day: due_day_i};
      desc_q <= has_description_i;
    end
    if (cmd_i.scan) begin
      pos_q  <= pos_c;
      head_q <= '0;
      left_q <= '0;
      case (op_e'(op_q))
        OP_ENQ: begin
          if (bad_c) st_q <= ST_INVALID;
          else if (past_c) st_q <= ST_PAST;
          else if (|dup) st_q <= ST_DUPLICATE;
          else if (count_q == CntW'(QueueDepth)) st_q <= ST_FULL;
          else st_q <= ST_OK;
        end
        OP_DEQ: begin
          if (count_q == '0) st_q <= ST_EMPTY;
          else begin
            st_q   <= ST_OK;
            head_q <= row_q[0];
          end
        end
        OP_QUERY: begin
          if (found_c) begin
            st_q   <= ST_OK;
            left_q <= (due_doy >= now_doy) ? (due_doy - now_doy + 9'd1) : 9'd0;
          end else st_q <= ST_NOT_FOUND;
        end
        default: st_q <= ST_INVALID;
      endcase
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (ins_q) begin
          if (CntW'(i) == pos_q) row_q[i] <= req_q;
          else if (CntW'(i) > pos_q && i > 0) row_q[i] <= row_q[(i > 0) ? i - 1 : 0];
        end else if (i < QueueDepth - 1) begin
          row_q[i] <= row_q[i + 1];
        end
      end
    end
  end

  assign res_status_o  = st_q;
  assign head_course_o = head_q.course;
  assign head_number_o = head_q.number;
  assign head_month_o  = head_q.month;
  assign head_day_o    = head_q.day;
  assign days_left_o   = left_q;

endmodule

FILE: tb/sv/due_date_sorted_queue_tb.sv
// Testbench for the due-date sorted queue: drives enqueue, dequeue, query
// and bad-opcode items with random gaps and checks every result against a
// built-in predictor. Depends on ddsq_pkg and the due_date_sorted_queue RTL.

module due_date_sorted_queue_tb;
  import ddsq_pkg::*;

  // Predictor of the queue plus the store of expected results.
  class due_queue_board;
    typedef struct packed {
      logic [2:0] status;
      logic [2:0] course;
      logic [7:0] number;
      logic [3:0] month;
      logic [4:0] day;
      logic [8:0] days_left;
    } answer_t;

    entry_t    rows[$];
    answer_t   pending[$];
    logic [3:0] now_month;
    logic [4:0] now_day;
    int        mismatches;
    int        depth;

    function new(int d);
      depth = d;
      now_month = 4'd1;
      now_day = 5'd1;
      mismatches = 0;
    endfunction

    function automatic int doy(logic [3:0] m, logic [4:0] d);
      int table_c[13];
      int mm;
      table_c = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      mm = (m < 1) ? 1 : ((m > 12) ? 12 : m);
      return table_c[mm] + d;
    endfunction

    function automatic int mlen(logic [3:0] m);
      int lens[16];
      lens = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0};
      return lens[m];
    endfunction

    // Works out the result of one accepted item and updates the shadow queue.
    function void note_item(logic [1:0] op, logic [2:0] c, logic [7:0] n,
                            logic [3:0] m, logic [4:0] d, logic desc);
      answer_t a;
      int pos;
      bit dup;
      entry_t e;
      a = '0;
      case (op)
        OP_ENQ: begin
          dup = 0;
          foreach (rows[i])
            if (rows[i] == {c, n, m, d}) dup = 1;
          if (c > MAX_COURSE || !desc || mlen(m) == 0 || d < 1 || d > mlen(m))
            a.status = ST_INVALID;
          else if (doy(m, d) < doy(now_month, now_day)) a.status = ST_PAST;
          else if (dup) a.status = ST_DUPLICATE;
          else if (rows.size() >= depth) a.status = ST_FULL;
          else begin
            a.status = ST_OK;
            pos = 0;
            while (pos < rows.size() && {rows[pos].month, rows[pos].day} <= {m, d}) pos++;
            e = {c, n, m, d};
            rows.insert(pos, e);
          end
        end
        OP_DEQ: begin
          if (rows.size() == 0) a.status = ST_EMPTY;
          else begin
            e = rows.pop_front();
            a.status = ST_OK;
            a.course = e.course; a.number = e.number;
            a.month = e.month; a.day = e.day;
          end
        end
        OP_QUERY: begin
          a.status = ST_NOT_FOUND;
          foreach (rows[i]) begin
            if (a.status == ST_NOT_FOUND && rows[i].course == c) begin
              a.status = ST_OK;
              if (doy(rows[i].month, rows[i].day) >= doy(now_month, now_day))
                a.days_left = 9'(doy(rows[i].month, rows[i].day) -
                                 doy(now_month, now_day) + 1);
            end
          end
        end
        default: a.status = ST_INVALID;
      endcase
      pending.push_back(a);
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st=%0d c=%0d n=%0d m=%0d d=%0d left=%0d,",
                    " got st=%0d c=%0d n=%0d m=%0d d=%0d left=%0d"},
                   want.status, want.course, want.number, want.month, want.day,
                   want.days_left, got.status, got.course, got.number, got.month,
                   got.day, got.days_left);
      end
    endfunction
  endclass

  localparam int DEPTH = 16;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [2:0] course_code_i = '0;
  logic [7:0] assignment_number_i = '0;
  logic [3:0] due_month_i = '0;
  logic [4:0] due_day_i = '0;
  logic has_description_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o, head_course_o;
  logic [7:0] head_number_o;
  logic [3:0] head_month_o;
  logic [4:0] head_day_o;
  logic [8:0] days_left_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [4:0] cfg_data_i = '0;

  due_queue_board board = new(DEPTH);
  bit sending_done = 0;
  bit timed_out = 0;
  int idle_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  due_date_sorted_queue #(.QUEUE_DEPTH(DEPTH)) uut (.*);

  // Mostly short gaps, with an occasional long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  // Offers one item and holds it until the handshake completes; the
  // prediction is made at the accepting edge so it sees the right state.
  // Valid is dropped after each item, which costs nothing since the block
  // takes no new item until the previous result has been taken.
  task automatic send_item(logic [1:0] op, logic [2:0] c, logic [7:0] n,
                           logic [3:0] m, logic [4:0] d, logic desc);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    course_code_i <= c;
    assignment_number_i <= n;
    due_month_i <= m;
    due_day_i <= d;
    has_description_i <= desc;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(op, c, n, m, d, desc);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_cycles(gap_len());
  endtask

  // Returns once every expected result has been taken and the block has
  // had time to settle back to idle.
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk_i);
    wait_cycles(8);
  endtask

  task automatic set_today(logic [3:0] m, logic [4:0] d);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_TODAY_MONTH;
    cfg_data_i <= {1'b0, m};
    @(posedge clk_i);
    cfg_index_i <= CFG_TODAY_DAY;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.now_month = m;
    board.now_day = d;
    @(posedge clk_i);
  endtask

  // Random item: mostly enqueues, many well-formed with few numbers so that
  // sorting ties, duplicates and a full queue occur; noise on every field.
  task automatic random_item();
    int r;
    logic [3:0] m;
    logic [4:0] d;
    r = $urandom_range(0, 99);
    m = 4'($urandom_range(1, 12));
    d = 5'($urandom_range(1, 28));
    if ($urandom_range(0, 3) == 0) d = 5'($urandom_range(25, 31));
    if (r < 45)
      send_item(OP_ENQ, 3'($urandom_range(0, 5)), 8'($urandom_range(0, 3)), m, d, 1'b1);
    else if (r < 55)
      send_item(OP_ENQ, 3'($urandom), 8'($urandom), 4'($urandom), 5'($urandom),
                1'($urandom));
    else if (r < 80)
      send_item(OP_DEQ, 3'($urandom), 8'($urandom), 4'($urandom), 5'($urandom),
                1'($urandom));
    else if (r < 97)
      send_item(OP_QUERY, 3'($urandom), 8'($urandom), 4'($urandom), 5'($urandom),
                1'($urandom));
    else
      send_item(OP_BAD, 3'($urandom), 8'($urandom), 4'($urandom), 5'($urandom),
                1'($urandom));
  endtask

  // Receiver: random stalls, checks each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result({status_o, head_course_o, head_number_o, head_month_o,
                          head_day_o, days_left_o});
  end

  initial begin
    int g;
    wait (rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      g = gap_len();
      if (g != 0) begin
        out_ready_i <= 1'b0;
        wait_cycles(g);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wait_cycles(11);
    rst_ni <= 1'b1;
    wait_cycles(2);

    // Directed part at reset today (January 1).
    send_item(OP_DEQ, 3'd0, 8'd0, 4'd0, 5'd0, 1'b0);         // empty queue
    send_item(OP_QUERY, 3'd2, 8'd0, 4'd0, 5'd0, 1'b0);       // not found
    send_item(OP_ENQ, 3'd6, 8'd1, 4'd3, 5'd3, 1'b1);         // bad course
    send_item(OP_ENQ, 3'd7, 8'd1, 4'd3, 5'd3, 1'b1);
    send_item(OP_ENQ, 3'd1, 8'd1, 4'd3, 5'd3, 1'b0);         // no description
    send_item(OP_ENQ, 3'd1, 8'd1, 4'd2, 5'd29, 1'b1);        // no leap day
    send_item(OP_ENQ, 3'd1, 8'd1, 4'd0, 5'd5, 1'b1);         // month zero
    send_item(OP_ENQ, 3'd1, 8'd1, 4'd15, 5'd5, 1'b1);        // month too large
    send_item(OP_ENQ, 3'd1, 8'd1, 4'd4, 5'd0, 1'b1);         // day zero
    send_item(OP_ENQ, 3'd0, 8'd255, 4'd12, 5'd31, 1'b1);
    send_item(OP_ENQ, 3'd5, 8'd0, 4'd1, 5'd1, 1'b1);         // due today
    send_item(OP_ENQ, 3'd5, 8'd0, 4'd1, 5'd1, 1'b1);         // duplicate
    send_item(OP_ENQ, 3'd2, 8'd7, 4'd1, 5'd1, 1'b1);         // tie, goes after
    send_item(OP_QUERY, 3'd5, 8'd0, 4'd0, 5'd0, 1'b0);
    send_item(OP_QUERY, 3'd0, 8'd0, 4'd0, 5'd0, 1'b0);
    send_item(OP_QUERY, 3'd7, 8'd0, 4'd0, 5'd0, 1'b0);
    send_item(OP_BAD, 3'd0, 8'd0, 4'd0, 5'd0, 1'b0);
    // Fill to capacity, then two more.
    for (int i = 0; i < DEPTH - 2; i++)
      send_item(OP_ENQ, 3'd3, i[7:0], 4'd6, 5'd15, 1'b1);
    send_item(OP_ENQ, 3'd4, 8'd9, 4'd6, 5'd15, 1'b1);        // full

    set_today(4'd12, 5'd31);                                 // latest date
    send_item(OP_QUERY, 3'd5, 8'd0, 4'd0, 5'd0, 1'b0);       // now past due
    send_item(OP_QUERY, 3'd0, 8'd0, 4'd0, 5'd0, 1'b0);       // due today
    send_item(OP_ENQ, 3'd1, 8'd2, 4'd12, 5'd30, 1'b1);       // past
    for (int i = 0; i < DEPTH + 1; i++)
      send_item(OP_DEQ, 3'd0, 8'd0, 4'd0, 5'd0, 1'b0);

    set_today(4'd0, 5'd0);                                   // below range
    send_item(OP_ENQ, 3'd1, 8'd3, 4'd1, 5'd1, 1'b1);
    send_item(OP_QUERY, 3'd1, 8'd0, 4'd0, 5'd0, 1'b0);
    set_today(4'd15, 5'd31);                                 // above range
    send_item(OP_QUERY, 3'd1, 8'd0, 4'd0, 5'd0, 1'b0);

    // Random phases, each under its own today.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_today(4'd1, 5'd1);
      else set_today(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
      for (int k = 0; k < 100; k++) begin
        random_item();
        if (k == 50) drain();        // sender waits for every result
      end
    end

    drain();
    wait_cycles(20);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: files.f
src/ddsq_pkg.sv
src/ddsq_ctrl.sv
src/ddsq_datapath.sv
src/due_date_sorted_queue.sv
tb/sv/due_date_sorted_queue_tb.sv
